[src/first_fit_block_allocator_assert.svh]
// Assertion macros used by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define FFBA_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("allocator check failed in the same cycle");

// Next-cycle implication, ignored while in reset.
`define FFBA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("allocator check failed one cycle later");

`endif

[src/ffba_pkg.sv]
// Types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int FIELD_W = 11;
   localparam int MEM_SIZE = 1024;
   localparam int MAX_BLOCKS_DEFAULT = 64;

   localparam logic [FIELD_W-1:0] MEM_UNITS = FIELD_W'(MEM_SIZE);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic               action;
      logic [FIELD_W-1:0] request_size;
      logic [FIELD_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [FIELD_W-1:0] result_address;
      logic [FIELD_W-1:0] free_total;
   } rsp_type;

endpackage

[src/first_fit_block_allocator.sv]
// First-fit block allocator: address-ordered block list walked one entry per cycle.
//
//  channel  | ports                          | word
//  ---------+--------------------------------+---------------------------------------
//  request  | req_valid, req_stall, req_data | action, request_size, block_address
//  response | rsp_valid, rsp_stall, rsp_data | success, result_address, free_total
//
// An allocate that finds room walks the list, writes the new entry, then in ST_FIX
// rewrites the entry before it; a free, or an allocate whose walk finds no gap, goes
// from the walk to ST_DONE. The walk reads k list entries (1 to MAX_BLOCKS) over the
// single read port of the entry memory; zero-size or table-full allocates skip it.
// After reset the ST_INIT state writes the head entry; no word is taken meanwhile.
// A response word waits in the output register while rsp_stall is high; the next
// request is taken meanwhile, and its result holds until the register frees up.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffba_pkg::rsp_type rsp_data
);

   localparam int FW = ffba_pkg::FIELD_W;
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int LW = $clog2(MAX_BLOCKS + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

   typedef struct packed {
      logic [FW-1:0] end_addr;
      logic [FW-1:0] size;
      logic [FW-1:0] gap;
      logic [LW-1:0] link;
   } entry_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_FIX,
      ST_DONE
   } state_type;

   // entry table and recycled-slot stack
   entry_type      entry_mem [MAX_BLOCKS];
   logic [IW-1:0]  stack_mem [MAX_BLOCKS];

   state_type         state_ff, state_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     prev_idx_ff, prev_idx_in;
   entry_type         prev_ff, prev_in;
   entry_type         fix_ff, fix_in;
   logic [IW-1:0]     fix_idx_ff, fix_idx_in;
   ffba_pkg::req_type req_ff, req_in;
   logic              ok_ff, ok_in;
   logic [FW-1:0]     addr_ff, addr_in;
   logic [LW-1:0]     used_ff, used_in;
   logic [LW-1:0]     fresh_ff, fresh_in;
   logic [IW-1:0]     rec_ff, rec_in;
   logic [FW-1:0]     free_ff, free_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type rsp_ff, rsp_in;
   entry_type         rd_ff;
   logic [IW-1:0]     stack_q_ff;

   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   entry_type         mem_wd;
   logic [IW-1:0]     rd_idx;
   logic              stk_we;
   logic              accept;
   logic              full;
   logic [IW-1:0]     new_slot;
   logic [IW-1:0]     link_idx;
   logic              at_tail;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign full     = (used_ff == NULL_LINK);
   assign new_slot = (rec_ff != '0) ? stack_q_ff : fresh_ff[IW-1:0];
   assign link_idx = rd_ff.link[IW-1:0];
   assign at_tail  = (rd_ff.link == NULL_LINK);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_idx_in  = prev_idx_ff;
      prev_in      = prev_ff;
      fix_in       = fix_ff;
      fix_idx_in   = fix_idx_ff;
      req_in       = req_ff;
      ok_in        = ok_ff;
      addr_in      = addr_ff;
      used_in      = used_ff;
      fresh_in     = fresh_ff;
      rec_in       = rec_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = cur_ff;
      mem_wd       = rd_ff;
      rd_idx       = link_idx;
      stk_we       = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we          = 1'b1;
            mem_wa          = '0;
            mem_wd.end_addr = '0;
            mem_wd.size     = '0;
            mem_wd.gap      = ffba_pkg::MEM_UNITS;
            mem_wd.link     = NULL_LINK;
            state_in        = ST_IDLE;
         end
         ST_IDLE: begin
            rd_idx = '0;
            if (req_valid) begin
               req_in = req_data;
               cur_in = '0;
               if (req_data.action == ffba_pkg::ACT_ALLOC &&
                   (req_data.request_size == '0 || full)) begin
                  ok_in    = 1'b0;
                  addr_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (req_ff.action == ffba_pkg::ACT_ALLOC) begin
               if (rd_ff.gap >= req_ff.request_size) begin
                  // place the new block right after this entry
                  mem_we          = 1'b1;
                  mem_wa          = new_slot;
                  mem_wd.end_addr = FW'(rd_ff.end_addr + req_ff.request_size);
                  mem_wd.size     = req_ff.request_size;
                  mem_wd.gap      = FW'(rd_ff.gap - req_ff.request_size);
                  mem_wd.link     = rd_ff.link;
                  fix_in          = rd_ff;
                  fix_in.gap      = '0;
                  fix_in.link     = LW'(new_slot);
                  fix_idx_in      = cur_ff;
                  ok_in           = 1'b1;
                  addr_in         = FW'(rd_ff.end_addr + req_ff.request_size);
                  free_in         = FW'(free_ff - req_ff.request_size);
                  used_in         = LW'(used_ff + 1'b1);
                  if (rec_ff != '0) begin
                     rec_in = IW'(rec_ff - 1'b1);
                  end else begin
                     fresh_in = LW'(fresh_ff + 1'b1);
                  end
                  state_in = ST_FIX;
               end else if (at_tail) begin
                  ok_in    = 1'b0;
                  addr_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  cur_in = link_idx;
               end
            end else begin
               if (cur_ff != '0 && rd_ff.end_addr == req_ff.block_address) begin
                  // fold size and gap into the predecessor and unlink
                  mem_we      = 1'b1;
                  mem_wa      = prev_idx_ff;
                  mem_wd      = prev_ff;
                  mem_wd.gap  = FW'(prev_ff.gap + rd_ff.size + rd_ff.gap);
                  mem_wd.link = rd_ff.link;
                  stk_we      = 1'b1;
                  rec_in      = IW'(rec_ff + 1'b1);
                  used_in     = LW'(used_ff - 1'b1);
                  free_in     = FW'(free_ff + rd_ff.size);
                  ok_in       = 1'b1;
                  addr_in     = req_ff.block_address;
                  state_in    = ST_DONE;
               end else if (at_tail) begin
                  ok_in    = 1'b0;
                  addr_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  prev_in     = rd_ff;
                  prev_idx_in = cur_ff;
                  cur_in      = link_idx;
               end
            end
         end
         ST_FIX: begin
            mem_we   = 1'b1;
            mem_wa   = fix_idx_ff;
            mem_wd   = fix_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.success        = ok_ff;
               rsp_in.result_address = addr_ff;
               rsp_in.free_total     = free_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= entry_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[rec_ff] <= cur_ff;
      end
      if (accept) begin
         stack_q_ff <= stack_mem[IW'(rec_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         used_ff      <= LW'(1);
         fresh_ff     <= LW'(1);
         rec_ff       <= '0;
         free_ff      <= ffba_pkg::MEM_UNITS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fresh_ff     <= fresh_in;
         rec_ff       <= rec_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_idx_ff <= prev_idx_in;
      prev_ff     <= prev_in;
      fix_ff      <= fix_in;
      fix_idx_ff  <= fix_idx_in;
      req_ff      <= req_in;
      ok_ff       <= ok_in;
      addr_ff     <= addr_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "first_fit_block_allocator_assert.svh"

   `FFBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)
   `FFBA_ASSERT_IMPLY(a_slot_count, clock, reset, 1'b1, used_ff + LW'(rec_ff) == fresh_ff)
   `FFBA_ASSERT_IMPLY(a_free_bound, clock, reset, 1'b1, free_ff <= ffba_pkg::MEM_UNITS)
   `FFBA_ASSERT_IMPLY(a_success_addr, clock, reset, rsp_valid_ff && rsp_ff.success, rsp_ff.result_address != '0)

endmodule
